[design/cdsr_pkg.sv]
// ----------------------------------------------------------------------------
// cdsr_pkg
// Types and codes shared by the deque-with-search block.
// ----------------------------------------------------------------------------
package cdsr_pkg;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 32;
  localparam int OCC_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_FIND       = 3'd4,
    FN_REMOVE     = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // operation request handed to the sequencer
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    func_t              func;
  } req_t;

  // result word; packs to {occupancy, hit, status} from the top bit down
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic             hit;
    status_t          status;
  } res_t;

endpackage

[design/cdsr_store.sv]
// ----------------------------------------------------------------------------
// cdsr_store
// Value storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cdsr_store #(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/cdsr_seq.sv]
// ----------------------------------------------------------------------------
// cdsr_seq
// Sequencer for the deque: keeps front pointer and count, drives the store
// through one shared slot adder (scan and shift) and a comparator (scan).
// ----------------------------------------------------------------------------
module cdsr_seq #(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  cdsr_pkg::req_t           req,
  output logic                     ready,
  output logic                     res_valid,
  output cdsr_pkg::res_t           res,
  input  logic                     res_ready,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [DATA_WIDTH-1:0]    mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [DATA_WIDTH-1:0]    mem_rdata
);

  import cdsr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  state_t                state, state_next;
  logic [AW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         idx, idx_next;
  func_t                 func, func_next;
  logic [DATA_WIDTH-1:0] key, key_next;
  status_t               status, status_next;
  logic                  hit, hit_next;

  logic [DATA_WIDTH-1:0] req_key;
  logic [CW-1:0]         off;
  logic [CW-1:0]         sum;
  logic [AW-1:0]         slot;
  logic [CW-1:0]         idx_inc;
  logic                  full;
  logic                  empty;

  // keep the low DATA_WIDTH bits; sign-extend when the store is wider
  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_narrow
      assign req_key = req.value[DATA_WIDTH-1:0];
    end else begin : g_wide
      assign req_key = {{(DATA_WIDTH-VALUE_W){req.value[VALUE_W-1]}}, req.value};
    end
  endgenerate

  // shared slot unit: (front + off) mod DEPTH, off never exceeds DEPTH
  assign sum  = CW'(front) + off;
  assign slot = (sum >= CW'(DEPTH)) ? AW'(sum - CW'(DEPTH)) : AW'(sum);

  assign idx_inc = CW'(idx) + CW'(1);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);

  assign res.status    = status;
  assign res.hit       = hit;
  assign res.occupancy = OCC_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      front  <= '0;
      count  <= '0;
    end else begin
      state  <= state_next;
      front  <= front_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    func   <= func_next;
    key    <= key_next;
    status <= status_next;
    hit    <= hit_next;
  end

  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    idx_next    = idx;
    func_next   = func;
    key_next    = key;
    status_next = status;
    hit_next    = hit;
    off         = CW'(idx);
    mem_we      = 1'b0;
    mem_waddr   = slot;
    mem_wdata   = key;
    mem_re      = 1'b0;
    mem_raddr   = slot;
    ready       = 1'b0;
    res_valid   = 1'b0;

    unique case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (req_valid) begin
          func_next   = req.func;
          key_next    = req_key;
          status_next = ST_OK;
          hit_next    = 1'b0;
          idx_next    = '0;
          state_next  = S_DONE;
          case (req.func)
            FN_PUSH_FRONT: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                front_next = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
                mem_we     = 1'b1;
                mem_waddr  = front_next;
                mem_wdata  = req_key;
                count_next = count + CW'(1);
              end
            end
            FN_PUSH_BACK: begin
              off = count;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_wdata  = req_key;
                count_next = count + CW'(1);
              end
            end
            FN_POP_FRONT: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                front_next = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
                count_next = count - CW'(1);
              end
            end
            FN_POP_BACK: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            FN_FIND, FN_REMOVE: begin
              if (empty) begin
                status_next = ST_EMPTY;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN_RD: begin
        mem_re     = 1'b1;
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (mem_rdata == key) begin
          hit_next = 1'b1;
          if (func == FN_REMOVE) begin
            if (idx_inc < count) begin
              state_next = S_SHIFT_RD;
            end else begin
              count_next = count - CW'(1);
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (idx_inc == count) begin
          status_next = ST_MISS;
          state_next  = S_DONE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SCAN_RD;
        end
      end

      // close the gap: entry idx takes the value of entry idx + 1
      S_SHIFT_RD: begin
        off        = idx_inc;
        mem_re     = 1'b1;
        state_next = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_next  = idx + AW'(1);
        if (idx_inc + CW'(1) < count) begin
          state_next = S_SHIFT_RD;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

[design/circular_deque_search_remove_top.sv]
// ----------------------------------------------------------------------------
// circular_deque_search_remove_top
// Bounded deque of signed values with find and order-keeping remove.
// ----------------------------------------------------------------------------
// Input stream: one transaction per operation. tuser carries the operation
// code (push front, push back, pop front, pop back, find, remove), tdata the
// value. Output stream: one transaction per operation with status, hit flag
// and occupancy after the operation.
// Pushes, pops, unused codes and operations on an empty queue go from the
// idle state straight to the done state and on to the output register.
// Find reads and compares one entry at a time from the front, up to the
// match or, on a miss, through the whole occupancy. Remove then moves each
// value behind the match up one place, with a read and a write per value;
// the store's single read port takes one read per compare or moved entry.
// One operation is in flight at a time; s_axis_tready is high only while the
// sequencer is idle. A finished result sits in the output register, so the
// next operation is accepted while the receiver stalls; it completes and
// waits in the sequencer until that register frees.
// Reset empties the queue (front and count cleared); store contents are left.
// ----------------------------------------------------------------------------
module circular_deque_search_remove_top #(
  parameter int DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cdsr_pkg::VALUE_W-1:0]   s_axis_tdata,  // [31:0] value
  input  logic [cdsr_pkg::FUNC_W-1:0]    s_axis_tuser,  // [2:0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata   // [1:0] status, [2] hit, [7:3] occupancy
);

  import cdsr_pkg::*;

  localparam int AW = $clog2(DEPTH);

  req_t                  req;
  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign req.value = s_axis_tdata;
  assign req.func  = func_t'(s_axis_tuser);

  cdsr_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req       (req),
    .ready     (s_axis_tready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cdsr_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res;
    end
  end

endmodule

[design/cdsr_checker.sv]
// ----------------------------------------------------------------------------
// cdsr_checker
// Port-level checks for the deque block, bound to the top level.
// ----------------------------------------------------------------------------
module cdsr_checker #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  import cdsr_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // one operation at a time: ready drops after each accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an operation is in flight");

  // a dropped push only happens when the queue is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL) |-> m_axis_tdata[7:3] == 5'(DEPTH))
    else $error("full status with queue not full");

  // a hit always reports ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1:0] == ST_OK)
    else $error("hit with non-ok status");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind circular_deque_search_remove_top cdsr_checker #(.DEPTH(DEPTH)) u_cdsr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
